// ----- sv/kot_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword and operator tokenizer package
// Shared token codes, character codes and the queue entry type.
// ----------------------------------------------------------------------------
package kot_pkg;

    localparam int KIND_BITS   = 5;
    localparam int START_BITS  = 32;
    localparam int LEN_BITS    = 16;
    localparam int WINDOW_BITS = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [KIND_BITS-1:0] KIND_END     = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_DOT     = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_QUEST   = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_COLON   = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_QUOTE   = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_AND     = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_ANDAND  = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_OR      = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_OROR    = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_LT      = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_LE      = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_GT      = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_GE      = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_EQ      = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_IF      = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_DO      = 5'd22;
    localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd23;
    localparam logic [KIND_BITS-1:0] KIND_ELSE    = 5'd24;
    localparam logic [KIND_BITS-1:0] KIND_WHILE   = 5'd25;
    localparam logic [KIND_BITS-1:0] KIND_RETURN  = 5'd26;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd27;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_AMP    = 3'd1;
    localparam logic [2:0] OP_PIPE   = 3'd2;
    localparam logic [2:0] OP_LT     = 3'd3;
    localparam logic [2:0] OP_GT     = 3'd4;
    localparam logic [2:0] OP_ASSIGN = 3'd5;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;

    // Keyword spellings, first character in the lowest byte.
    localparam logic [WINDOW_BITS-1:0] KW_IF     = 48'h0000_0000_6669;
    localparam logic [WINDOW_BITS-1:0] KW_DO     = 48'h0000_0000_6F64;
    localparam logic [WINDOW_BITS-1:0] KW_INT    = 48'h0000_0074_6E69;
    localparam logic [WINDOW_BITS-1:0] KW_ELSE   = 48'h0000_6573_6C65;
    localparam logic [WINDOW_BITS-1:0] KW_WHILE  = 48'h0065_6C69_6877;
    localparam logic [WINDOW_BITS-1:0] KW_RETURN = 48'h6E72_7574_6572;

    // One accepted byte yields at most two tokens; only the first can be a word.
    typedef struct packed {
        logic [1:0]            count;
        logic [KIND_BITS-1:0]  kind0;
        logic [KIND_BITS-1:0]  kind1;
        logic [START_BITS-1:0] start;
        logic [LEN_BITS-1:0]   length;
    } t_entry;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

endpackage
`default_nettype wire

// ----- sv/keyword_operator_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword and operator tokenizer
// Turns a stream of source bytes into punctuation, operator, keyword,
// identifier and end tokens.
// ----------------------------------------------------------------------------
// The slave channel takes one source byte per beat; byte 0 ends a stream and
// yields an end token. The master channel gives one token per beat, with
// tlast on the final token caused by one input byte. A byte yields zero, one
// or two tokens. Operators & | < > = and words are held until the next byte
// decides them, so their tokens appear after that byte is taken.
// A byte is taken every cycle while the entry queue has room; a byte that
// yields two tokens gives two output beats through the back end's single
// output register. A token passes through the entry queue and the output
// register in turn. When the receiver stalls, the output register holds
// its beat and the four-entry queue fills before the slave side stalls.
// Reset clears the byte position, any open word or pending operator, the
// queue and the output valid flag.
// ----------------------------------------------------------------------------
module keyword_operator_tokenizer
    import kot_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [4:0] token_kind, [36:5] word_start,
                                             // [52:37] word_length, [55:53] zero
    output logic             m_axis_tlast    // last_of_run
);

    t_entry push_entry, head_entry;
    logic   push, pop, full, empty;

    kot_front #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_char       (s_axis_tdata),
        .i_queue_full (full),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    kot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_entry)
    );

    kot_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_entry),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- sv/kot_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts one source byte per cycle while the queue has room, tracks the
// open word and pending operator, and packs its tokens into a queue entry.
// ----------------------------------------------------------------------------
module kot_front
    import kot_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_char,
    input  wire logic       i_queue_full,
    output logic            o_ready,
    output logic            o_push,
    output t_entry          o_entry
);

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [2:0]               r_pend, n_pend;
    logic                     r_open, n_open;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [LENGTH_BITS-1:0]   r_count, n_count;
    logic [WINDOW_BITS-1:0]   r_window, n_window;

    logic                  accept;
    logic                  word_char;
    logic                  pre_valid, post_valid, done, dbl;
    logic [KIND_BITS-1:0]  pre_kind, post_kind, word_kind, single_kind;
    logic [START_BITS-1:0] pre_start;
    logic [LEN_BITS-1:0]   pre_len;
    logic [63:0]           begin_ext;
    logic [31:0]           count_ext;

    assign o_ready   = !i_queue_full;
    assign accept    = i_valid && o_ready;
    assign word_char = is_word_char(i_char);
    assign begin_ext = 64'(r_begin);
    assign count_ext = 32'(r_count);

    always_comb begin
        word_kind = KIND_IDENT;
        if (r_count == LENGTH_BITS'(2) && r_window == KW_IF) begin
            word_kind = KIND_IF;
        end else if (r_count == LENGTH_BITS'(2) && r_window == KW_DO) begin
            word_kind = KIND_DO;
        end else if (r_count == LENGTH_BITS'(3) && r_window == KW_INT) begin
            word_kind = KIND_INT;
        end else if (r_count == LENGTH_BITS'(4) && r_window == KW_ELSE) begin
            word_kind = KIND_ELSE;
        end else if (r_count == LENGTH_BITS'(5) && r_window == KW_WHILE) begin
            word_kind = KIND_WHILE;
        end else if (r_count == LENGTH_BITS'(6) && r_window == KW_RETURN) begin
            word_kind = KIND_RETURN;
        end
    end

    always_comb begin
        case (r_pend)
            OP_AMP:    single_kind = KIND_AND;
            OP_PIPE:   single_kind = KIND_OR;
            OP_LT:     single_kind = KIND_LT;
            OP_GT:     single_kind = KIND_GT;
            OP_ASSIGN: single_kind = KIND_ASSIGN;
            default:   single_kind = KIND_AND;
        endcase
        dbl = (r_pend == OP_AMP && i_char == CH_AMP) ||
              (r_pend == OP_PIPE && i_char == CH_PIPE) ||
              ((r_pend == OP_LT || r_pend == OP_GT || r_pend == OP_ASSIGN) &&
               i_char == CH_EQ);
    end

    always_comb begin
        n_pos     = r_pos + POSITION_BITS'(1);
        n_pend    = r_pend;
        n_open    = r_open;
        n_begin   = r_begin;
        n_count   = r_count;
        n_window  = r_window;
        pre_valid = 1'b0;
        pre_kind  = KIND_END;
        pre_start = '0;
        pre_len   = '0;
        done      = 1'b0;

        if (r_pend != OP_NONE) begin
            pre_valid = 1'b1;
            pre_kind  = dbl ? single_kind + KIND_BITS'(1) : single_kind;
            n_pend    = OP_NONE;
            done      = dbl;
        end else if (r_open) begin
            if (word_char) begin
                if (r_count < LENGTH_BITS'(6)) begin
                    n_window = r_window |
                               (WINDOW_BITS'(i_char) << {r_count[2:0], 3'b000});
                end
                if (r_count != {LENGTH_BITS{1'b1}}) begin
                    n_count = r_count + LENGTH_BITS'(1);
                end
                done = 1'b1;
            end else begin
                pre_valid = 1'b1;
                pre_kind  = word_kind;
                pre_start = begin_ext[START_BITS-1:0];
                pre_len   = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
                n_open    = 1'b0;
                n_count   = '0;
                n_window  = '0;
                n_begin   = '0;
            end
        end

        post_valid = 1'b0;
        post_kind  = KIND_END;
        if (!done) begin
            post_valid = 1'b1;
            case (i_char)
                CH_END:    post_kind = KIND_END;
                CH_LBRACE: post_kind = KIND_LBRACE;
                CH_RBRACE: post_kind = KIND_RBRACE;
                CH_LPAREN: post_kind = KIND_LPAREN;
                CH_RPAREN: post_kind = KIND_RPAREN;
                CH_DOT:    post_kind = KIND_DOT;
                CH_COMMA:  post_kind = KIND_COMMA;
                CH_QUEST:  post_kind = KIND_QUEST;
                CH_SEMI:   post_kind = KIND_SEMI;
                CH_COLON:  post_kind = KIND_COLON;
                CH_QUOTE:  post_kind = KIND_QUOTE;
                CH_AMP: begin
                    post_valid = 1'b0;
                    n_pend     = OP_AMP;
                end
                CH_PIPE: begin
                    post_valid = 1'b0;
                    n_pend     = OP_PIPE;
                end
                CH_LT: begin
                    post_valid = 1'b0;
                    n_pend     = OP_LT;
                end
                CH_GT: begin
                    post_valid = 1'b0;
                    n_pend     = OP_GT;
                end
                CH_EQ: begin
                    post_valid = 1'b0;
                    n_pend     = OP_ASSIGN;
                end
                default: begin
                    post_valid = 1'b0;
                    if (word_char) begin
                        n_open   = 1'b1;
                        n_begin  = r_pos;
                        n_count  = LENGTH_BITS'(1);
                        n_window = WINDOW_BITS'(i_char);
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_entry.count  = 2'(pre_valid) + 2'(post_valid);
        o_entry.kind0  = pre_valid ? pre_kind : post_kind;
        o_entry.kind1  = post_kind;
        o_entry.start  = pre_start;
        o_entry.length = pre_len;
        o_push         = accept && (pre_valid || post_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_pend   <= OP_NONE;
            r_open   <= 1'b0;
            r_begin  <= '0;
            r_count  <= '0;
            r_window <= '0;
        end else if (accept) begin
            r_pos    <= n_pos;
            r_pend   <= n_pend;
            r_open   <= n_open;
            r_begin  <= n_begin;
            r_count  <= n_count;
            r_window <= n_window;
        end
    end

endmodule
`default_nettype wire

// ----- sv/kot_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer entry queue
// Small first-in first-out buffer of token entries between front and back.
// ----------------------------------------------------------------------------
module kot_queue
    import kot_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr, r_rd;
    logic [QPTR_BITS:0]     r_used, n_used;
    logic                   do_pop;

    assign o_full  = (r_used == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_used == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_used = r_used;
        if (i_push && !do_pop) begin
            n_used = r_used + (QPTR_BITS+1)'(1);
        end else if (!i_push && do_pop) begin
            n_used = r_used - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_used <= '0;
        end else begin
            r_used <= n_used;
            if (i_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/kot_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer back end
// Splits each queue entry into one or two output beats and holds the
// current beat in an output register.
// ----------------------------------------------------------------------------
module kot_back
    import kot_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  t_entry           i_head,
    output logic             o_pop,
    input  wire logic        i_tready,
    output logic             o_tvalid,
    output logic [55:0]      o_tdata,
    output logic             o_tlast
);

    logic                  r_valid;
    logic                  r_sub;
    logic [KIND_BITS-1:0]  r_kind;
    logic [START_BITS-1:0] r_start;
    logic [LEN_BITS-1:0]   r_len;
    logic                  r_last;
    logic                  load, beat_last;

    assign load      = !i_empty && (!r_valid || i_tready);
    assign beat_last = r_sub || (i_head.count == 2'd1);
    assign o_pop     = load && beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= !beat_last;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= beat_last;
            if (r_sub) begin
                r_kind  <= i_head.kind1;
                r_start <= '0;
                r_len   <= '0;
            end else begin
                r_kind  <= i_head.kind0;
                r_start <= i_head.start;
                r_len   <= i_head.length;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = r_last;
    assign o_tdata  = {3'b000, r_len, r_start, r_kind};

endmodule
`default_nettype wire
